// File: hdl/ftp_pkg.sv
package ftp_pkg;

  // Storage sizes.
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned OUT_BYTES   = 8192;
  localparam int unsigned IN_BYTES    = 256;

  // Address, length and count widths follow from the sizes.
  localparam int unsigned FRAME_AW = $clog2(FRAME_BYTES);
  localparam int unsigned LEN_W    = $clog2(FRAME_BYTES + 1);
  localparam int unsigned OUT_AW   = $clog2(OUT_BYTES);
  localparam int unsigned OUT_CW   = $clog2(OUT_BYTES + 1);
  localparam int unsigned IN_AW    = $clog2(IN_BYTES);
  localparam int unsigned IN_CW    = $clog2(IN_BYTES + 1);
  localparam int unsigned SUM_W    = ((OUT_CW > LEN_W) ? OUT_CW : LEN_W) + 2;

  // Item opcodes.
  localparam logic [2:0] OP_BUS_READ   = 3'd0;
  localparam logic [2:0] OP_BUS_WRITE  = 3'd1;
  localparam logic [2:0] OP_LINK_RX    = 3'd2;
  localparam logic [2:0] OP_TX_SLOT    = 3'd3;
  localparam logic [2:0] OP_CONNECT    = 3'd4;
  localparam logic [2:0] OP_DISCONNECT = 3'd5;

  // Register map.
  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_FRAME  = 2'd1;
  localparam logic [1:0] REG_IN     = 2'd2;
  localparam logic [1:0] REG_IN_LEN = 2'd3;

  // Control commands.
  localparam logic [7:0] CMD_END_FRAME    = 8'd1;
  localparam logic [7:0] CMD_LOCKSTEP_ON  = 8'd2;
  localparam logic [7:0] CMD_LOCKSTEP_OFF = 8'd3;

  localparam logic [7:0] SYNC_BYTE     = 8'hAA;
  localparam logic [7:0] LEN_SAT       = 8'hFF;
  localparam logic [7:0] ACK_BYTE_RST  = 8'd6;
  localparam logic [1:0] HDR_LAST      = 2'd2;

  // Where the read data of a result comes from.
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_IN,
    SRC_OUT
  } res_src_e;

endpackage

// File: hdl/ftp_ram.sv
module ftp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/framed_telemetry_port.sv
// Framed telemetry port. Each input transfer carries one command (bus read,
// bus write, received link byte, transmit slot, connect or disconnect) and
// yields exactly one result transfer. The frame store, the outbound queue and
// the inbound FIFO sit in three RAMs with registered read ports; there is no
// clearing pass after reset. Most commands are offered as a result once the
// output register is free: the accepting edge updates the pointers and issues
// any RAM access, and the done state then loads the result into the output
// register. The next command is accepted only once that load is made. An
// end-frame command that fits first passes through the header and copy
// states. The header state writes the sync byte and the two length bytes.
// The copy sequencer then moves one payload byte per cycle from the frame
// store to the outbound queue and writes the last byte it read in the
// following cycle. A new command is accepted while a previous result still
// waits in the output register; its own result then waits until the output
// register is free.
module framed_telemetry_port
  import ftp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write channel (ack byte).
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // Command channel.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [1:0] reg_addr_i,
  input  logic [7:0] data_i,
  // Result channel.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       awaiting_ack_o,
  output logic       frame_dropped_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_COPY = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [LEN_W-1:0]  frame_len_q, frame_len_d;
  logic [OUT_AW-1:0] out_head_q, out_head_d;
  logic [OUT_CW-1:0] out_count_q, out_count_d;
  logic [IN_AW-1:0]  in_head_q, in_head_d;
  logic [IN_CW-1:0]  in_count_q, in_count_d;
  logic              lockstep_q, lockstep_d;
  logic              gate_q, gate_d;
  logic              link_q, link_d;
  logic [7:0]        ack_byte_q;
  logic [1:0]        hdr_idx_q, hdr_idx_d;
  logic [LEN_W-1:0]  copy_idx_q, copy_idx_d;
  logic              copy_pend_q, copy_pend_d;
  logic [7:0]        res_rd_q, res_rd_d;
  res_src_e          res_src_q, res_src_d;
  logic              res_drop_q, res_drop_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        read_data_q;
  logic              tx_valid_q;
  logic [7:0]        tx_byte_q;
  logic              awaiting_q;
  logic              dropped_q;
  logic              out_load;

  // RAM ports.
  logic                frame_we, frame_re;
  logic [FRAME_AW-1:0] frame_waddr, frame_raddr;
  logic [7:0]          frame_rdata;
  logic                oq_we, oq_re;
  logic [OUT_AW-1:0]   oq_waddr;
  logic [7:0]          oq_wdata, oq_rdata;
  logic                iq_we, iq_re;
  logic [IN_AW-1:0]    iq_waddr;
  logic [7:0]          iq_rdata;

  // Derived positions and flags.
  logic              accept;
  logic [OUT_CW:0]   oq_sum;
  logic [OUT_AW-1:0] oq_tail;
  logic [IN_CW:0]    iq_sum;
  logic [IN_AW-1:0]  iq_tail;
  logic [OUT_AW-1:0] out_head_inc;
  logic [IN_AW-1:0]  in_head_inc;
  logic              in_full;
  logic              frame_fits;
  logic              copy_go;
  logic [7:0]        in_len_sat;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Tail positions: head plus count, wrapped once.
  assign oq_sum  = (OUT_CW + 1)'(out_head_q) + (OUT_CW + 1)'(out_count_q);
  assign oq_tail = (oq_sum >= (OUT_CW + 1)'(OUT_BYTES)) ?
                   OUT_AW'(oq_sum - (OUT_CW + 1)'(OUT_BYTES)) : OUT_AW'(oq_sum);
  assign iq_sum  = (IN_CW + 1)'(in_head_q) + (IN_CW + 1)'(in_count_q);
  assign iq_tail = (iq_sum >= (IN_CW + 1)'(IN_BYTES)) ?
                   IN_AW'(iq_sum - (IN_CW + 1)'(IN_BYTES)) : IN_AW'(iq_sum);

  assign out_head_inc = (out_head_q == OUT_AW'(OUT_BYTES - 1)) ? '0 : out_head_q + 1'b1;
  assign in_head_inc  = (in_head_q == IN_AW'(IN_BYTES - 1)) ? '0 : in_head_q + 1'b1;
  assign in_full      = (in_count_q >= IN_CW'(IN_BYTES));

  // A frame fits when the header and payload leave the queue within bounds.
  assign frame_fits = (SUM_W'(out_count_q) + SUM_W'(frame_len_q) + SUM_W'(3))
                      <= SUM_W'(OUT_BYTES);
  assign copy_go    = (copy_idx_q < frame_len_q);
  assign in_len_sat = (in_count_q > IN_CW'(LEN_SAT)) ? LEN_SAT : 8'(in_count_q);

  // Result register is free when empty or being drained this cycle.
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    frame_len_d = frame_len_q;
    out_head_d  = out_head_q;
    out_count_d = out_count_q;
    in_head_d   = in_head_q;
    in_count_d  = in_count_q;
    lockstep_d  = lockstep_q;
    gate_d      = gate_q;
    link_d      = link_q;
    hdr_idx_d   = hdr_idx_q;
    copy_idx_d  = copy_idx_q;
    copy_pend_d = copy_pend_q;
    res_rd_d    = res_rd_q;
    res_src_d   = res_src_q;
    res_drop_d  = res_drop_q;

    frame_we    = 1'b0;
    frame_waddr = FRAME_AW'(frame_len_q);
    frame_re    = 1'b0;
    frame_raddr = FRAME_AW'(copy_idx_q);
    oq_we       = 1'b0;
    oq_waddr    = oq_tail;
    oq_wdata    = frame_rdata;
    oq_re       = 1'b0;
    iq_we       = 1'b0;
    iq_waddr    = iq_tail;
    iq_re       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_rd_d   = '0;
          res_src_d  = SRC_NONE;
          res_drop_d = 1'b0;
          state_d    = ST_DONE;
          unique case (opcode_i)
            OP_BUS_READ: begin
              unique case (reg_addr_i)
                REG_CTRL:   res_rd_d = {6'b0, (in_count_q != '0), link_q};
                REG_IN: begin
                  if (in_count_q != '0) begin
                    iq_re      = 1'b1;
                    res_src_d  = SRC_IN;
                    in_head_d  = in_head_inc;
                    in_count_d = in_count_q - 1'b1;
                  end
                end
                REG_IN_LEN: res_rd_d = in_len_sat;
                default:    res_rd_d = '0;
              endcase
            end
            OP_BUS_WRITE: begin
              if (reg_addr_i == REG_FRAME) begin
                if (frame_len_q < LEN_W'(FRAME_BYTES)) begin
                  frame_we    = 1'b1;
                  frame_len_d = frame_len_q + 1'b1;
                end
              end else if (reg_addr_i == REG_CTRL) begin
                if (data_i == CMD_END_FRAME) begin
                  if (frame_fits) begin
                    hdr_idx_d = '0;
                    state_d   = ST_HDR;
                  end else begin
                    frame_len_d = '0;
                    res_drop_d  = 1'b1;
                  end
                end else if (data_i == CMD_LOCKSTEP_ON) begin
                  lockstep_d = 1'b1;
                end else if (data_i == CMD_LOCKSTEP_OFF) begin
                  lockstep_d = 1'b0;
                  gate_d     = 1'b0;
                end
              end
            end
            OP_LINK_RX: begin
              if (link_q) begin
                if (gate_q && (data_i == ack_byte_q)) begin
                  gate_d = 1'b0;
                end else if (in_full) begin
                  // Oldest byte is overwritten by the new one.
                  iq_we     = 1'b1;
                  iq_waddr  = in_head_q;
                  in_head_d = in_head_inc;
                end else begin
                  iq_we      = 1'b1;
                  in_count_d = in_count_q + 1'b1;
                end
              end
            end
            OP_TX_SLOT: begin
              if (link_q && (out_count_q != '0)) begin
                oq_re       = 1'b1;
                res_src_d   = SRC_OUT;
                out_head_d  = out_head_inc;
                out_count_d = out_count_q - 1'b1;
              end
            end
            OP_CONNECT: begin
              link_d     = 1'b1;
              in_head_d  = '0;
              in_count_d = '0;
            end
            OP_DISCONNECT: link_d = 1'b0;
            default: ;
          endcase
        end
      end

      // Sync byte, then low and high length bytes.
      ST_HDR: begin
        oq_we       = 1'b1;
        out_count_d = out_count_q + 1'b1;
        case (hdr_idx_q)
          2'd0:    oq_wdata = SYNC_BYTE;
          2'd1:    oq_wdata = 8'(frame_len_q);
          default: oq_wdata = 8'(frame_len_q >> 8);
        endcase
        hdr_idx_d = hdr_idx_q + 1'b1;
        if (hdr_idx_q == HDR_LAST) begin
          copy_idx_d  = '0;
          copy_pend_d = 1'b0;
          state_d     = ST_COPY;
        end
      end

      // Read one payload byte per cycle and write the previous one.
      ST_COPY: begin
        if (copy_pend_q) begin
          oq_we       = 1'b1;
          out_count_d = out_count_q + 1'b1;
        end
        if (copy_go) begin
          frame_re    = 1'b1;
          copy_idx_d  = copy_idx_q + 1'b1;
          copy_pend_d = 1'b1;
        end else begin
          copy_pend_d = 1'b0;
          frame_len_d = '0;
          gate_d      = gate_q | lockstep_q;
          state_d     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control and pointer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_len_q <= '0;
      out_head_q  <= '0;
      out_count_q <= '0;
      in_head_q   <= '0;
      in_count_q  <= '0;
      lockstep_q  <= 1'b0;
      gate_q      <= 1'b0;
      link_q      <= 1'b0;
      ack_byte_q  <= ACK_BYTE_RST;
      hdr_idx_q   <= '0;
      copy_idx_q  <= '0;
      copy_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_len_q <= frame_len_d;
      out_head_q  <= out_head_d;
      out_count_q <= out_count_d;
      in_head_q   <= in_head_d;
      in_count_q  <= in_count_d;
      lockstep_q  <= lockstep_d;
      gate_q      <= gate_d;
      link_q      <= link_d;
      hdr_idx_q   <= hdr_idx_d;
      copy_idx_q  <= copy_idx_d;
      copy_pend_q <= copy_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ack_byte_q <= cfg_data_i;
      end
    end
  end

  // Pending result and output payload registers.
  always_ff @(posedge clk_i) begin
    res_rd_q   <= res_rd_d;
    res_src_q  <= res_src_d;
    res_drop_q <= res_drop_d;
    if (out_load) begin
      read_data_q <= (res_src_q == SRC_IN) ? iq_rdata : res_rd_q;
      tx_valid_q  <= (res_src_q == SRC_OUT);
      tx_byte_q   <= (res_src_q == SRC_OUT) ? oq_rdata : 8'h00;
      awaiting_q  <= gate_q;
      dropped_q   <= res_drop_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign tx_valid_o      = tx_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign awaiting_ack_o  = awaiting_q;
  assign frame_dropped_o = dropped_q;

  // Frame under construction.
  ftp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (data_i),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  // Outbound byte queue.
  ftp_ram #(
    .WIDTH (8),
    .DEPTH (OUT_BYTES)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (oq_we),
    .waddr_i (oq_waddr),
    .wdata_i (oq_wdata),
    .re_i    (oq_re),
    .raddr_i (out_head_q),
    .rdata_o (oq_rdata)
  );

  // Inbound byte FIFO.
  ftp_ram #(
    .WIDTH (8),
    .DEPTH (IN_BYTES)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (iq_we),
    .waddr_i (iq_waddr),
    .wdata_i (data_i),
    .re_i    (iq_re),
    .raddr_i (in_head_q),
    .rdata_o (iq_rdata)
  );

endmodule

// File: tb/sv/ftp_result_checker.sv
`timescale 1ns / 100ps

// Watches the configuration, command and result channels of the telemetry
// port, predicts one result per accepted command and compares each result
// transfer with the oldest prediction.
module ftp_result_checker
  import ftp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] opcode_i,
  input  logic [1:0] reg_addr_i,
  input  logic [7:0] data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] read_data_i,
  input  logic       tx_valid_i,
  input  logic [7:0] tx_byte_i,
  input  logic       awaiting_ack_i,
  input  logic       frame_dropped_i,
  output int         pending_o,
  output int         fail_count_o
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       awaiting_ack;
    logic       frame_dropped;
  } port_result_t;

  // Results predicted for accepted commands, oldest first.
  port_result_t due_results[$];
  port_result_t oldest;

  // Shadow copy of the port state.
  logic [7:0]  frame_mem [FRAME_BYTES];
  int unsigned frame_len;
  logic [7:0]  out_mem [OUT_BYTES];
  int unsigned out_rd;
  int unsigned out_cnt;
  logic [7:0]  in_mem [IN_BYTES];
  int unsigned in_rd;
  int unsigned in_cnt;
  bit          lockstep_on;
  bit          gate_armed;
  bit          link_up;
  logic [7:0]  ack_val;
  int          fails = 0;

  function automatic void queue_out_byte(input logic [7:0] b);
    out_mem[(out_rd + out_cnt) % OUT_BYTES] = b;
    out_cnt++;
  endfunction

  // Applies one command to the shadow state and returns the result it yields.
  function automatic port_result_t next_port_result(input logic [2:0] op,
                                                    input logic [1:0] addr,
                                                    input logic [7:0] d);
    port_result_t r;
    r = '0;
    case (op)
      OP_BUS_READ: begin
        case (addr)
          REG_CTRL: r.read_data = {6'd0, in_cnt != 0, link_up};
          REG_IN: begin
            if (in_cnt != 0) begin
              r.read_data = in_mem[in_rd];
              in_rd = (in_rd + 1) % IN_BYTES;
              in_cnt--;
            end
          end
          REG_IN_LEN: r.read_data = (in_cnt > 255) ? LEN_SAT : 8'(in_cnt);
          default: ;
        endcase
      end
      OP_BUS_WRITE: begin
        if (addr == REG_FRAME) begin
          // Bytes past the frame capacity are dropped.
          if (frame_len < FRAME_BYTES) begin
            frame_mem[frame_len] = d;
            frame_len++;
          end
        end else if (addr == REG_CTRL) begin
          case (d)
            CMD_END_FRAME: begin
              // The frame goes out whole with its header, or not at all.
              if (out_cnt + frame_len + 3 > OUT_BYTES) begin
                r.frame_dropped = 1'b1;
              end else begin
                queue_out_byte(SYNC_BYTE);
                queue_out_byte(8'(frame_len));
                queue_out_byte(8'(frame_len >> 8));
                for (int i = 0; i < frame_len; i++) queue_out_byte(frame_mem[i]);
                if (lockstep_on) gate_armed = 1'b1;
              end
              frame_len = 0;
            end
            CMD_LOCKSTEP_ON: lockstep_on = 1'b1;
            CMD_LOCKSTEP_OFF: begin
              lockstep_on = 1'b0;
              gate_armed  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      OP_LINK_RX: begin
        if (link_up) begin
          // An ack releases an armed gate; anything else enters the FIFO,
          // pushing out the oldest byte when it is full.
          if (gate_armed && d == ack_val) begin
            gate_armed = 1'b0;
          end else begin
            if (in_cnt >= IN_BYTES) begin
              in_rd = (in_rd + 1) % IN_BYTES;
              in_cnt--;
            end
            in_mem[(in_rd + in_cnt) % IN_BYTES] = d;
            in_cnt++;
          end
        end
      end
      OP_TX_SLOT: begin
        if (link_up && out_cnt != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = out_mem[out_rd];
          out_rd = (out_rd + 1) % OUT_BYTES;
          out_cnt--;
        end
      end
      OP_CONNECT: begin
        link_up = 1'b1;
        in_rd   = 0;
        in_cnt  = 0;
      end
      OP_DISCONNECT: link_up = 1'b0;
      default: ;
    endcase
    r.awaiting_ack = gate_armed;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endtask

  // Predictions are queued before results are retired, so a command and a
  // result in the same cycle are handled in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_results.delete();
      frame_len    = 0;
      out_rd       = 0;
      out_cnt      = 0;
      in_rd        = 0;
      in_cnt       = 0;
      lockstep_on  = 1'b0;
      gate_armed   = 1'b0;
      link_up      = 1'b0;
      ack_val      = ACK_BYTE_RST;
      fails        = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) ack_val = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        due_results.insert(due_results.size(),
                           next_port_result(opcode_i, reg_addr_i, data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with no command outstanding", $time);
          fails++;
        end else begin
          oldest = due_results[0];
          due_results.delete(0);
          check_field("read_data", oldest.read_data, read_data_i);
          check_field("tx_valid", 8'(oldest.tx_valid), 8'(tx_valid_i));
          check_field("tx_byte", oldest.tx_byte, tx_byte_i);
          check_field("awaiting_ack", 8'(oldest.awaiting_ack), 8'(awaiting_ack_i));
          check_field("frame_dropped", 8'(oldest.frame_dropped), 8'(frame_dropped_i));
        end
      end
      pending_o    <= due_results.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

// Drives commands, configuration writes and result backpressure into the
// telemetry port and gives the verdict from the checker's failure and pending counts.
module tb_top
  import ftp_pkg::*;
();

  localparam int StallLimit    = 50000;
  localparam int SettleCycles  = 16;
  localparam int ItemsPerPhase = 160;
  localparam int PhaseCount    = 8;

  // Opcodes the port does not decode.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] opcode;
  logic [1:0] reg_addr;
  logic [7:0] data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       awaiting_ack;
  logic       frame_dropped;
  int         pending;
  int         fail_count;

  int         send_idle_pct = 36;
  int         recv_stall_pct = 36;
  logic [7:0] ack_setting = ACK_BYTE_RST;
  int         sent = 0;
  int         idle_cycles;

  framed_telemetry_port dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .reg_addr_i     (reg_addr),
    .data_i         (data),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_data_o    (read_data),
    .tx_valid_o     (tx_valid),
    .tx_byte_o      (tx_byte),
    .awaiting_ack_o (awaiting_ack),
    .frame_dropped_o(frame_dropped)
  );

  ftp_result_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .opcode_i       (opcode),
    .reg_addr_i     (reg_addr),
    .data_i         (data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .read_data_i    (read_data),
    .tx_valid_i     (tx_valid),
    .tx_byte_i      (tx_byte),
    .awaiting_ack_i (awaiting_ack),
    .frame_dropped_i(frame_dropped),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result backpressure at the rate of the current phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // End the run once no transfer of any kind has happened for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("framed_telemetry_port: mismatch");
    $finish;
  end

  // Received bytes hit the ack value often enough to release the gate.
  function automatic logic [7:0] link_byte();
    return ($urandom_range(3) == 0) ? ack_setting : 8'($urandom);
  endfunction

  // Offers one command and returns at the edge where it is transferred. Valid
  // is only lowered when an idle cycle follows.
  task automatic send_item(input logic [2:0] op, input logic [1:0] addr,
                           input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    reg_addr <= addr;
    data     <= d;
    do @(posedge clk); while (!in_ready);
    if (op <= OP_DISCONNECT) sent++;
  endtask

  // Waits until every predicted result has been transferred, then lets the
  // port settle before anything is reconfigured.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_ack(input logic [7:0] v);
    cfg_valid   <= 1'b1;
    cfg_data    <= v;
    ack_setting = v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Runs the inbound FIFO past its capacity with the link up and the gate
  // clear.
  task automatic run_capacity_case();
    int i;
    // Overflow the inbound FIFO, then read the saturated length and the oldest
    // surviving bytes.
    for (i = 0; i < IN_BYTES + 40; i++) send_item(OP_LINK_RX, 2'($urandom), 8'($urandom));
    send_item(OP_BUS_READ, REG_IN_LEN, 8'h00);
    for (i = 0; i < 3; i++) send_item(OP_BUS_READ, REG_IN, 8'h00);
    send_item(OP_BUS_READ, REG_IN_LEN, 8'h00);
    send_item(OP_CONNECT, REG_CTRL, 8'h00);
    send_item(OP_BUS_READ, REG_IN_LEN, 8'h00);
  endtask

  // Random traffic, mostly complete frame and inbound sequences with random
  // content, with link events and unconstrained commands mixed in.
  task automatic run_random(input int quota);
    int first;
    int pick;
    int len;
    int i;
    first = sent;
    while (sent - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        // Build a frame, send it, and drain it with acks sprinkled in.
        if ($urandom_range(3) == 0) begin
          send_item(OP_BUS_WRITE, REG_CTRL,
                    $urandom_range(1) ? CMD_LOCKSTEP_ON : CMD_LOCKSTEP_OFF);
        end
        len = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(8);
        for (i = 0; i < len; i++) send_item(OP_BUS_WRITE, REG_FRAME, 8'($urandom));
        send_item(OP_BUS_WRITE, REG_CTRL, CMD_END_FRAME);
        len = len + 3 + $urandom_range(3) - $urandom_range(2);
        for (i = 0; i < len; i++) begin
          if ($urandom_range(4) == 0) send_item(OP_LINK_RX, 2'($urandom), link_byte());
          send_item(OP_TX_SLOT, 2'($urandom), 8'($urandom));
        end
      end else if (pick < 65) begin
        // Receive a burst of bytes, now and then enough to overflow, and read
        // some of them back.
        len = ($urandom_range(50) == 0) ? $urandom_range(250, 270) : $urandom_range(6);
        for (i = 0; i < len; i++) send_item(OP_LINK_RX, 2'($urandom), link_byte());
        len = $urandom_range(len / 2, len + 2);
        for (i = 0; i < len; i++) begin
          send_item(OP_BUS_READ, ($urandom_range(3) == 0) ? 2'($urandom) : REG_IN,
                    8'($urandom));
        end
      end else if (pick < 75) begin
        send_item(($urandom_range(3) == 0) ? OP_DISCONNECT : OP_CONNECT,
                  2'($urandom), 8'($urandom));
      end else begin
        case ($urandom_range(2))
          0: send_item(3'($urandom), 2'($urandom), 8'($urandom_range(4)));
          1: send_item(3'($urandom), 2'($urandom), link_byte());
          default: send_item(3'($urandom), 2'($urandom), 8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 8'h00;
    in_valid  = 1'b0;
    opcode    = OP_BUS_READ;
    reg_addr  = REG_CTRL;
    data      = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands with the reset ack value.
    send_item(OP_BUS_READ, REG_CTRL, 8'h00);
    send_item(OP_TX_SLOT, REG_CTRL, 8'h00);
    send_item(OP_LINK_RX, REG_IN, 8'hFF);
    send_item(OP_CONNECT, REG_CTRL, 8'h00);
    send_item(OP_BUS_READ, REG_IN, 8'h00);
    send_item(OP_BUS_READ, REG_FRAME, 8'hFF);
    send_item(OP_BUS_WRITE, REG_IN, 8'h5A);
    send_item(OP_BUS_WRITE, REG_IN_LEN, 8'hA5);
    send_item(OP_BUS_WRITE, REG_CTRL, 8'hFF);
    send_item(OP_BUS_WRITE, REG_FRAME, 8'h00);
    send_item(OP_BUS_WRITE, REG_FRAME, 8'hFF);
    send_item(OP_BUS_WRITE, REG_CTRL, CMD_LOCKSTEP_ON);
    send_item(OP_BUS_WRITE, REG_CTRL, CMD_END_FRAME);
    send_item(OP_LINK_RX, REG_CTRL, 8'h55);
    send_item(OP_LINK_RX, REG_CTRL, ACK_BYTE_RST);
    send_item(OP_LINK_RX, REG_CTRL, ACK_BYTE_RST);
    send_item(OP_BUS_READ, REG_CTRL, 8'h00);
    send_item(OP_BUS_READ, REG_IN_LEN, 8'h00);
    send_item(OP_BUS_READ, REG_IN, 8'h00);
    send_item(OP_BUS_WRITE, REG_CTRL, CMD_END_FRAME);
    send_item(OP_BUS_WRITE, REG_CTRL, CMD_LOCKSTEP_OFF);
    send_item(OP_DISCONNECT, REG_CTRL, 8'h00);
    send_item(OP_TX_SLOT, REG_IN, 8'h00);
    send_item(OP_SPARE_A, REG_FRAME, 8'h01);
    send_item(OP_SPARE_B, REG_IN_LEN, 8'h01);
    send_item(OP_CONNECT, REG_CTRL, 8'h00);
    send_item(OP_CONNECT, REG_IN_LEN, 8'hFF);
    // Two frames left eight bytes queued; the last slot finds it empty.
    for (int i = 0; i < 9; i++) send_item(OP_TX_SLOT, REG_FRAME, 8'h00);

    run_capacity_case();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 36;
          recv_stall_pct = 36;
        end
      endcase
      case (phase)
        0: write_ack(8'h00);
        1: write_ack(8'hFF);
        3: write_ack(ACK_BYTE_RST);
        5: write_ack(SYNC_BYTE);
        default: write_ack(8'($urandom));
      endcase
      send_item(OP_CONNECT, REG_CTRL, 8'h00);
      run_random(ItemsPerPhase);
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("framed_telemetry_port: match");
    end else begin
      $display("framed_telemetry_port: mismatch");
    end
    $finish;
  end

endmodule

// File: framed_telemetry_port.f
hdl/ftp_pkg.sv
hdl/ftp_ram.sv
hdl/framed_telemetry_port.sv
tb/sv/ftp_result_checker.sv
tb/sv/tb_top.sv
